// ----- rtl/core/htfr_pkg.sv -----
// shared constants and types for the header/trailer frame receiver
// no dependencies; used by header_trailer_frame_receiver and htfr_core, not by htfr_in_stage
`timescale 1ns / 1ps
`default_nettype none

package htfr_pkg;

	localparam int unsigned FRAME_MAX_DEF = 10;

	localparam logic [7:0] HDR_FIRST  = 8'h2C;
	localparam logic [7:0] HDR_SECOND = 8'h12;
	localparam logic [7:0] END_MARK   = 8'h5B;

	// smallest frame, final byte included, that gives a result
	localparam int unsigned MIN_FRAME = 5;

	typedef struct packed {
		logic       hit;
		logic [7:0] bias;
		logic [7:0] sign_byte;
		logic [7:0] label;
		logic [7:0] channel;
		logic       ended_by_marker;
	} result_t;

	typedef struct packed {
		logic in_body;
		logic in_swallow;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/core/header_trailer_frame_receiver.sv -----
// channel  | valid    | ready     | payload
// rx       | rx_valid | rx_ready  | rx_byte
// res      | res_valid| res_ready | bias, sign_byte, label, channel, ended_by_marker
//
// one byte per cycle sustained unless res stalls; a byte goes from rx to res
// through the input register, then the result register behind the frame state machine
// a result waits in its register while the next byte is taken in; input stalls
// only when both the input stage and the result register are full
// reset clears the handshake state, the frame phase and the byte count
// depends on htfr_pkg, htfr_in_stage, htfr_core
`timescale 1ns / 1ps
`default_nettype none

module header_trailer_frame_receiver #(
	parameter int unsigned FRAME_MAX = htfr_pkg::FRAME_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [7:0]      bias,
	output logic [7:0]      sign_byte,
	output logic [7:0]      label,
	output logic [7:0]      channel,
	output logic            ended_by_marker
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              out_valid_q;
	htfr_pkg::result_t res;
	htfr_pkg::status_t status;
	htfr_pkg::result_t out_q;

	// an item moves on when the result register is empty or being drained
	assign advance = valid_s1 && (!out_valid_q || res_ready);

	htfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	htfr_core #(
		.FRAME_MAX (FRAME_MAX)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_in (byte_s1),
		.res     (res),
		.status  (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.hit;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit) begin
			out_q <= res;
		end
	end

	assign res_valid       = out_valid_q;
	assign bias            = out_q.bias;
	assign sign_byte       = out_q.sign_byte;
	assign label           = out_q.label;
	assign channel         = out_q.channel;
	assign ended_by_marker = out_q.ended_by_marker;

`ifndef NO_ASSERTIONS
	// a result only comes out of the body phase
	a_hit_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		res.hit |-> status.in_body)
		else $error("result raised outside the body phase");

	// a frame that produced a result is followed by the swallow phase
	a_swallow_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.hit) |=> status.in_swallow)
		else $error("no swallow phase after a result");

	// an unread result is never overwritten or dropped
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_ready) |-> !advance)
		else $error("result register overwritten while stalled");

	// an empty input stage always takes a new item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> rx_ready)
		else $error("input stage empty but not ready");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/htfr_in_stage.sv -----
// input register stage of the frame receiver: holds one received byte
// depends on nothing outside this file
`timescale 1ns / 1ps
`default_nettype none

module htfr_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	logic vld_s1;

	// stage frees up in the same cycle its item moves on
	assign rx_ready = !vld_s1 || advance;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx_ready) begin
			vld_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/htfr_core.sv -----
// frame state machine: header hunt, body capture, end detection, result build
// depends on htfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module htfr_core #(
	parameter int unsigned FRAME_MAX = htfr_pkg::FRAME_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] byte_in,
	output htfr_pkg::result_t res,
	output htfr_pkg::status_t status
);

	localparam int unsigned CntW = $clog2(FRAME_MAX);
	localparam logic [CntW-1:0] CntLast = CntW'(FRAME_MAX - 1);
	localparam logic [CntW-1:0] CntMin  = CntW'(htfr_pkg::MIN_FRAME - 1);

	typedef enum logic [1:0] {
		HUNT1,
		HUNT2,
		BODY,
		SWALLOW
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [CntW-1:0] count_q, count_d;
	logic [7:0]      recent_q [4];
	logic            push;
	logic            hit;
	logic            marker;
	logic            frame_end;

	assign marker    = (byte_in == htfr_pkg::END_MARK);
	assign frame_end = (count_q >= CntLast) || marker;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		push    = 1'b0;
		hit     = 1'b0;
		unique case (phase_q)
			HUNT1: begin
				if (byte_in == htfr_pkg::HDR_FIRST) begin
					push    = 1'b1;
					count_d = CntW'(1);
					phase_d = HUNT2;
				end else begin
					count_d = '0;
				end
			end
			HUNT2: begin
				if (byte_in == htfr_pkg::HDR_SECOND) begin
					push    = 1'b1;
					count_d = count_q + CntW'(1);
					phase_d = BODY;
				end else begin
					count_d = '0;
					phase_d = HUNT1;
				end
			end
			BODY: begin
				if (frame_end) begin
					// short frames close silently
					hit     = (count_q >= CntMin);
					phase_d = SWALLOW;
				end else begin
					push    = 1'b1;
					count_d = count_q + CntW'(1);
				end
			end
			SWALLOW: begin
				count_d = '0;
				phase_d = HUNT1;
			end
			default: begin
				count_d = '0;
				phase_d = HUNT1;
			end
		endcase
	end

	assign res.hit             = hit;
	assign res.bias            = recent_q[0];
	assign res.sign_byte       = recent_q[1];
	assign res.label           = recent_q[2];
	assign res.channel         = recent_q[3];
	assign res.ended_by_marker = marker;

	assign status.in_body    = (phase_q == BODY);
	assign status.in_swallow = (phase_q == SWALLOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HUNT1;
			count_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	// last four frame bytes, entry 3 newest
	always_ff @(posedge clk) begin
		if (advance && push) begin
			recent_q[0] <= recent_q[1];
			recent_q[1] <= recent_q[2];
			recent_q[2] <= recent_q[3];
			recent_q[3] <= byte_in;
		end
	end

endmodule

`default_nettype wire

// ----- test/tb_header_trailer_frame_receiver.sv -----
// testbench for header_trailer_frame_receiver: byte stream in, frame fields out
// predicts each result from its own model of the frame state; depends on htfr_pkg
`timescale 1ns / 1ps

module tb_header_trailer_frame_receiver;

	typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, IN_BODY, SWALLOW} frame_phase_t;

	logic       clk;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_ready;
	logic [7:0] rx_byte;
	logic       res_valid;
	logic       res_ready;
	logic [7:0] bias;
	logic [7:0] sign_byte;
	logic [7:0] label;
	logic [7:0] channel;
	logic       ended_by_marker;

	// frame tracking copy
	frame_phase_t      frame_phase;
	logic [3:0]        frame_len;
	logic [7:0]        last_bytes [4];
	htfr_pkg::result_t pending_results [$];

	int mismatch_count = 0;
	int bytes_sent = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_request = 0;

	header_trailer_frame_receiver u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_ready       (rx_ready),
		.rx_byte        (rx_byte),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.bias           (bias),
		.sign_byte      (sign_byte),
		.label          (label),
		.channel        (channel),
		.ended_by_marker(ended_by_marker)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic void store_frame_byte(logic [7:0] b);
		last_bytes[0] = last_bytes[1];
		last_bytes[1] = last_bytes[2];
		last_bytes[2] = last_bytes[3];
		last_bytes[3] = b;
		if (frame_len != 4'hF) begin
			frame_len = frame_len + 4'd1;
		end
	endfunction

	function automatic void predict_frame_byte(logic [7:0] b);
		int                total;
		logic              marker;
		htfr_pkg::result_t r;
		case (frame_phase)
			HUNT_FIRST: begin
				frame_len = 4'd0;
				if (b == htfr_pkg::HDR_FIRST) begin
					store_frame_byte(b);
					frame_phase = HUNT_SECOND;
				end
			end
			HUNT_SECOND: begin
				if (b == htfr_pkg::HDR_SECOND) begin
					store_frame_byte(b);
					frame_phase = IN_BODY;
				end else begin
					frame_phase = HUNT_FIRST;
					frame_len = 4'd0;
				end
			end
			IN_BODY: begin
				total = int'(frame_len) + 1;
				marker = (b == htfr_pkg::END_MARK);
				if (total >= int'(htfr_pkg::FRAME_MAX_DEF) || marker) begin
					// frames too short to hold four bytes before the final one give nothing
					if (total >= int'(htfr_pkg::MIN_FRAME)) begin
						r.hit = 1'b1;
						r.bias = last_bytes[0];
						r.sign_byte = last_bytes[1];
						r.label = last_bytes[2];
						r.channel = last_bytes[3];
						r.ended_by_marker = marker;
						pending_results.push_back(r);
					end
					frame_phase = SWALLOW;
				end else begin
					store_frame_byte(b);
				end
			end
			default: begin
				frame_phase = HUNT_FIRST;
				frame_len = 4'd0;
			end
		endcase
	endfunction

	function automatic logic [7:0] any_body_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == htfr_pkg::END_MARK);
		return b;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic offer_rx_byte(logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		predict_frame_byte(b);
		bytes_sent++;
	endtask

	task automatic send_good_frame(int body_len, bit by_marker);
		offer_rx_byte(htfr_pkg::HDR_FIRST);
		offer_rx_byte(htfr_pkg::HDR_SECOND);
		repeat (body_len) offer_rx_byte(any_body_byte());
		if (by_marker) begin
			offer_rx_byte(htfr_pkg::END_MARK);
		end else begin
			offer_rx_byte(any_body_byte());
		end
		// byte after the frame is dropped, even a header byte
		offer_rx_byte(($urandom_range(3) == 0) ? htfr_pkg::HDR_FIRST
			: 8'($urandom_range(255)));
	endtask

	task automatic test_frame_cases();
		// repeated first header byte drops back to hunting
		offer_rx_byte(htfr_pkg::HDR_FIRST);
		offer_rx_byte(htfr_pkg::HDR_FIRST);
		offer_rx_byte(htfr_pkg::HDR_SECOND);
		// short frame, then a header byte that gets swallowed
		offer_rx_byte(htfr_pkg::HDR_FIRST);
		offer_rx_byte(htfr_pkg::HDR_SECOND);
		offer_rx_byte(8'h01);
		offer_rx_byte(htfr_pkg::END_MARK);
		offer_rx_byte(htfr_pkg::HDR_FIRST);
		// smallest frame with a result
		offer_rx_byte(htfr_pkg::HDR_FIRST);
		offer_rx_byte(htfr_pkg::HDR_SECOND);
		offer_rx_byte(8'hFF);
		offer_rx_byte(8'h00);
		offer_rx_byte(htfr_pkg::END_MARK);
		offer_rx_byte(8'h7E);
		// end marker on the byte that reaches the length limit
		offer_rx_byte(htfr_pkg::HDR_FIRST);
		offer_rx_byte(htfr_pkg::HDR_SECOND);
		for (int i = 0; i < int'(htfr_pkg::FRAME_MAX_DEF) - 3; i++) begin
			offer_rx_byte(i[0] ? 8'hFF : 8'h00);
		end
		offer_rx_byte(htfr_pkg::END_MARK);
		offer_rx_byte(8'hA5);
	endtask

	task automatic test_random_stream(int n_bytes);
		int stop_at;
		int pick;
		int body_len;
		bit by_marker;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				by_marker = 1'($urandom_range(1));
				body_len = by_marker ? $urandom_range(int'(htfr_pkg::FRAME_MAX_DEF) - 3)
					: int'(htfr_pkg::FRAME_MAX_DEF) - 3;
				send_good_frame(body_len, by_marker);
			end else if (pick < 88) begin
				// broken header
				offer_rx_byte(htfr_pkg::HDR_FIRST);
				offer_rx_byte($urandom_range(1) ? htfr_pkg::HDR_FIRST
					: 8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 4)) offer_rx_byte(8'($urandom_range(255)));
			end
		end
	endtask

	task automatic test_result_backpressure();
		// sink holds off while frames keep coming, so the input must stall
		hold_request = 300;
		repeat (8) send_good_frame(3, 1'b1);
	endtask

	initial begin : result_sink
		int                hold_left;
		htfr_pkg::result_t want;
		hold_left = 0;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no item pending: bias=%h sign_byte=%h label=%h channel=%h",
						bias, sign_byte, label, channel);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("bias", want.bias, bias);
					check_field("sign_byte", want.sign_byte, sign_byte);
					check_field("label", want.label, label);
					check_field("channel", want.channel, channel);
					check_field("ended_by_marker", 8'(want.ended_by_marker), 8'(ended_by_marker));
				end
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		frame_phase = HUNT_FIRST;
		frame_len = 4'd0;
		foreach (last_bytes[i]) last_bytes[i] = 8'h00;
		tx_idle_pct = 14;
		rx_idle_pct = 57;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_frame_cases();
		test_random_stream(650);
		tx_idle_pct = 57;
		rx_idle_pct = 14;
		test_random_stream(650);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_result_backpressure();
		test_random_stream(580);
		rx_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
